// ----- rtl/zone_watering_sequencer_macros.svh -----
// ============================================================================
// Zone watering sequencer assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ============================================================================
`ifndef ZONE_WATERING_SEQUENCER_MACROS_SVH
`define ZONE_WATERING_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define ZWS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define ZWS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZWS_ASSERT(label, clk, rstn, prop, msg)
`define ZWS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/zws_pkg.sv -----
// ============================================================================
// Zone watering sequencer package
// Shared types, codes and reset values.
// ============================================================================
package zws_pkg;

    // Command codes (input tuser)
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    // Register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PREOPEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELIEF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERZONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_SEQ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_CNT  = 3'd5;

    // Status message codes
    localparam logic [3:0] MSG_NONE      = 4'd0;
    localparam logic [3:0] MSG_SELECT    = 4'd1;
    localparam logic [3:0] MSG_EMPTY     = 4'd2;
    localparam logic [3:0] MSG_SEQERR    = 4'd3;
    localparam logic [3:0] MSG_ZONEERR   = 4'd4;
    localparam logic [3:0] MSG_OPENING   = 4'd5;
    localparam logic [3:0] MSG_WATERING  = 4'd6;
    localparam logic [3:0] MSG_DEPRESS   = 4'd7;
    localparam logic [3:0] MSG_NEXT      = 4'd8;
    localparam logic [3:0] MSG_COMPLETE  = 4'd9;
    localparam logic [3:0] MSG_CANCELLED = 4'd10;

    // Phase codes as reported on the result word
    localparam logic [2:0] PHC_IDLE      = 3'd0;
    localparam logic [2:0] PHC_PREOPEN   = 3'd1;
    localparam logic [2:0] PHC_RUNNING   = 3'd2;
    localparam logic [2:0] PHC_RELIEF    = 3'd3;
    localparam logic [2:0] PHC_INTERZONE = 3'd4;
    localparam logic [2:0] PHC_COMPLETE  = 3'd5;
    localparam logic [2:0] PHC_FAULT     = 3'd6;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_PREOPEN   = 7'b0000010,
        PH_RUNNING   = 7'b0000100,
        PH_RELIEF    = 7'b0001000,
        PH_INTERZONE = 7'b0010000,
        PH_COMPLETE  = 7'b0100000,
        PH_FAULT     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [15:0] preopen_ms;
        logic [15:0] relief_ms;
        logic [15:0] interzone_ms;
        logic [3:0]  sequence_length;
        logic [31:0] zone_sequence;
        logic [3:0]  zone_count;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        cycle_on;
        logic        pump_on;
        logic [3:0]  open_zone;
        logic [23:0] watering_time;
        logic [23:0] time_left;
        logic [15:0] phase_count;
        logic [23:0] watering_count;
        logic [3:0]  message;
    } state_t;

    // Result word, last field in the low bits
    typedef struct packed {
        logic [6:0]  pad;
        logic        start_ok;
        logic [3:0]  message_code;
        logic [2:0]  step_index;
        logic        cycle_active;
        logic [23:0] remaining_ms;
        logic [3:0]  active_zone;
        logic        pump_on;
        logic [2:0]  phase;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        16'd1000, 16'd1000, 16'd1000, 4'd1, 32'd1, 4'd4
    };

    localparam state_t STATE_RESET = '{
        PH_IDLE, 1'b0, 1'b0, 4'd0, 24'd0, 24'd0, 16'd0, 24'd0, MSG_NONE
    };

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:      code = PHC_IDLE;
            PH_PREOPEN:   code = PHC_PREOPEN;
            PH_RUNNING:   code = PHC_RUNNING;
            PH_RELIEF:    code = PHC_RELIEF;
            PH_INTERZONE: code = PHC_INTERZONE;
            PH_COMPLETE:  code = PHC_COMPLETE;
            PH_FAULT:     code = PHC_FAULT;
            default:      code = PHC_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/zws_step.sv -----
// ============================================================================
// Zone watering sequencer step logic
// Next state of the sequencer for one command word.
// ============================================================================
module zws_step #(
    parameter int unsigned MAX_SEQUENCE = 8,
    parameter int unsigned ZONE_BITS    = 4,
    parameter int unsigned SEQ_W        = 3
) (
    input  zws_pkg::cfg_t     cfg,
    input  zws_pkg::state_t   cur,
    input  logic [SEQ_W-1:0]  seq_pos_cur,
    input  logic [1:0]        cmd,
    input  logic [23:0]       duration_ms,
    input  logic              zone_fail,
    output zws_pkg::state_t   nxt,
    output logic [SEQ_W-1:0]  seq_pos_nxt,
    output logic              start_ok
);

    localparam int unsigned LEN_W = 5;
    localparam int unsigned CMP_W = (ZONE_BITS > 4) ? ZONE_BITS : 4;

    logic [LEN_W-1:0]     used_len;
    logic [SEQ_W-1:0]     pos_inc;
    logic [SEQ_W-1:0]     open_idx;
    logic [7:0]           shamt;
    logic [31:0]          seq_shift;
    logic                 in_range;
    logic [ZONE_BITS-1:0] zone_raw;
    logic [CMP_W-1:0]     zone_ext;
    logic [CMP_W-1:0]     count_ext;
    logic                 zone_ok;
    logic                 is_last;
    logic [15:0]          pc_dec;
    logic [23:0]          wc_dec;
    logic                 do_open;

    // Fail-safe stop: everything off, phase as given
    function automatic zws_pkg::state_t stop_all(input zws_pkg::state_t s,
                                                 input zws_pkg::phase_t ph);
        zws_pkg::state_t r;
        r                = s;
        r.pump_on        = 1'b0;
        r.open_zone      = 4'd0;
        r.time_left      = 24'd0;
        r.cycle_on       = 1'b0;
        r.phase_count    = 16'd0;
        r.watering_count = 24'd0;
        r.phase          = ph;
        return r;
    endfunction

    assign used_len = (LEN_W'(cfg.sequence_length) > LEN_W'(MAX_SEQUENCE)) ?
                      LEN_W'(MAX_SEQUENCE) : LEN_W'(cfg.sequence_length);
    assign pos_inc  = seq_pos_cur + SEQ_W'(1);
    assign is_last  = (LEN_W'(seq_pos_cur) + LEN_W'(1)) >= used_len;

    // Zone lookup: first entry on start, next entry at end of interzone
    assign open_idx  = (cmd == zws_pkg::CMD_START) ? '0 : pos_inc;
    assign shamt     = 8'(open_idx) * 8'(ZONE_BITS);
    assign in_range  = (LEN_W'(open_idx) < used_len) && (shamt < 8'd32);
    assign seq_shift = cfg.zone_sequence >> shamt;
    assign zone_raw  = in_range ? seq_shift[ZONE_BITS-1:0] : '0;
    assign zone_ext  = CMP_W'(zone_raw);
    assign count_ext = CMP_W'(cfg.zone_count);
    assign zone_ok   = (zone_ext != '0) && (zone_ext <= count_ext);

    // Saturating countdowns
    assign pc_dec = cur.phase_count - 16'(cur.phase_count != 16'd0);
    assign wc_dec = cur.watering_count - 24'(cur.watering_count != 24'd0);

    always_comb begin
        nxt         = cur;
        seq_pos_nxt = seq_pos_cur;
        start_ok    = 1'b0;
        do_open     = 1'b0;

        case (cmd)
            zws_pkg::CMD_TICK: begin
                if (cur.cycle_on) begin
                    unique case (cur.phase)
                        zws_pkg::PH_PREOPEN: begin
                            nxt.phase_count = pc_dec;
                            if (pc_dec == 16'd0) begin
                                nxt.pump_on        = 1'b1;
                                nxt.watering_count = cur.watering_time;
                                nxt.phase          = zws_pkg::PH_RUNNING;
                                nxt.message        = zws_pkg::MSG_WATERING;
                            end
                        end
                        zws_pkg::PH_RUNNING: begin
                            nxt.watering_count = wc_dec;
                            nxt.time_left      = wc_dec;
                            if (wc_dec == 24'd0) begin
                                nxt.pump_on     = 1'b0;
                                nxt.phase       = zws_pkg::PH_RELIEF;
                                nxt.message     = zws_pkg::MSG_DEPRESS;
                                nxt.phase_count = cfg.relief_ms;
                            end
                        end
                        zws_pkg::PH_RELIEF: begin
                            nxt.phase_count = pc_dec;
                            if (pc_dec == 16'd0) begin
                                nxt.open_zone = 4'd0;
                                if (is_last) begin
                                    nxt         = stop_all(nxt, zws_pkg::PH_COMPLETE);
                                    nxt.message = zws_pkg::MSG_COMPLETE;
                                end else begin
                                    nxt.phase       = zws_pkg::PH_INTERZONE;
                                    nxt.message     = zws_pkg::MSG_NEXT;
                                    nxt.phase_count = cfg.interzone_ms;
                                end
                            end
                        end
                        zws_pkg::PH_INTERZONE: begin
                            nxt.phase_count = pc_dec;
                            if (pc_dec == 16'd0) begin
                                seq_pos_nxt = pos_inc;
                                do_open     = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            zws_pkg::CMD_START: begin
                if (duration_ms == 24'd0) begin
                    nxt.message = zws_pkg::MSG_SELECT;
                end else if (cfg.sequence_length == 4'd0) begin
                    nxt.phase   = zws_pkg::PH_FAULT;
                    nxt.message = zws_pkg::MSG_EMPTY;
                end else begin
                    nxt.pump_on        = 1'b0;
                    nxt.open_zone      = 4'd0;
                    seq_pos_nxt        = '0;
                    nxt.watering_time  = duration_ms;
                    nxt.time_left      = duration_ms;
                    nxt.watering_count = 24'd0;
                    nxt.cycle_on       = 1'b1;
                    do_open            = 1'b1;
                    start_ok           = zone_ok && !zone_fail;
                end
            end
            zws_pkg::CMD_CANCEL: begin
                nxt         = stop_all(cur, zws_pkg::PH_IDLE);
                nxt.message = zws_pkg::MSG_CANCELLED;
            end
            default: begin
            end
        endcase

        // Open the selected zone, or fall into the fail-safe stop
        if (do_open) begin
            if (!zone_ok) begin
                nxt         = stop_all(nxt, zws_pkg::PH_FAULT);
                nxt.message = zws_pkg::MSG_SEQERR;
            end else if (zone_fail) begin
                nxt         = stop_all(nxt, zws_pkg::PH_FAULT);
                nxt.message = zws_pkg::MSG_ZONEERR;
            end else begin
                nxt.open_zone   = zone_ext[3:0];
                nxt.phase       = zws_pkg::PH_PREOPEN;
                nxt.message     = zws_pkg::MSG_OPENING;
                nxt.phase_count = cfg.preopen_ms;
            end
        end
    end

endmodule

// ----- rtl/zone_watering_sequencer.sv -----
// ============================================================================
// Zone watering sequencer
// Steps irrigation zones through pre-open, pumping, relief and pause phases.
// ============================================================================
// Path: the input register loads at the accept edge; one pass of the step logic
//   fills the result register once the result slot is free or being drained.
// Throughput: one word per cycle while m_axis_tready holds; the state update is one combinational pass.
// Reset (aresetn low, synchronous): both stages empty, sequencer idle,
//   registers back to their power-on values.
`include "zone_watering_sequencer_macros.svh"

module zone_watering_sequencer #(
    parameter int unsigned MAX_SEQUENCE = 8,   // 1..16 zone list entries
    parameter int unsigned ZONE_BITS    = 4    // 1..8 bits per list entry
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [23:0] duration_ms, [24] zone_fail
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd

    // Status stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [2:0] phase, [3] pump_on,
                                        // [7:4] active_zone, [31:8] remaining_ms,
                                        // [32] cycle_active, [35:33] step_index,
                                        // [39:36] message_code, [40] start_ok

    // Register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned SEQ_W = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [23:0] in_dur_reg;
    logic        in_fail_reg;

    // ------------------------------------------------------------------
    // Sequencer state and configuration
    // ------------------------------------------------------------------
    zws_pkg::state_t  st_reg;
    zws_pkg::state_t  st_next;
    logic [SEQ_W-1:0] seq_pos_reg;
    logic [SEQ_W-1:0] seq_pos_next;
    zws_pkg::cfg_t    cfg_reg;
    logic             start_ok;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    zws_pkg::result_t  out_data_reg;
    zws_pkg::result_t  result;

    logic advance;
    logic s_accept;
    logic m_accept;

    // A word moves from the input stage into the result stage whenever the
    // result slot is free or being drained this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= s_axis_tuser;
            in_dur_reg  <= s_axis_tdata[23:0];
            in_fail_reg <= s_axis_tdata[24];
        end
    end

    zws_step #(
        .MAX_SEQUENCE (MAX_SEQUENCE),
        .ZONE_BITS    (ZONE_BITS),
        .SEQ_W        (SEQ_W)
    ) u_step (
        .cfg         (cfg_reg),
        .cur         (st_reg),
        .seq_pos_cur (seq_pos_reg),
        .cmd         (in_cmd_reg),
        .duration_ms (in_dur_reg),
        .zone_fail   (in_fail_reg),
        .nxt         (st_next),
        .seq_pos_nxt (seq_pos_next),
        .start_ok    (start_ok)
    );

    // Status after the step
    always_comb begin
        result              = '0;
        result.phase        = zws_pkg::phase_code(st_next.phase);
        result.pump_on      = st_next.pump_on;
        result.active_zone  = st_next.open_zone;
        result.remaining_ms = st_next.time_left;
        result.cycle_active = st_next.cycle_on;
        result.step_index   = 3'(seq_pos_next);
        result.message_code = st_next.message;
        result.start_ok     = start_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= zws_pkg::STATE_RESET;
            seq_pos_reg <= '0;
        end else if (advance) begin
            st_reg      <= st_next;
            seq_pos_reg <= seq_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_accept) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // Register file; writes to unused indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= zws_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                zws_pkg::REG_PREOPEN:   cfg_reg.preopen_ms      <= cfg_data[15:0];
                zws_pkg::REG_RELIEF:    cfg_reg.relief_ms       <= cfg_data[15:0];
                zws_pkg::REG_INTERZONE: cfg_reg.interzone_ms    <= cfg_data[15:0];
                zws_pkg::REG_SEQ_LEN:   cfg_reg.sequence_length <= cfg_data[3:0];
                zws_pkg::REG_ZONE_SEQ:  cfg_reg.zone_sequence   <= cfg_data;
                zws_pkg::REG_ZONE_CNT:  cfg_reg.zone_count      <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ZWS_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !in_valid_reg && !out_valid_reg, "stages not empty after reset")
    `ZWS_ASSERT(a_advance_fills, aclk, aresetn, advance |=> out_valid_reg, "result lost after step")
    `ZWS_ASSERT(a_start_ok_opens, aclk, aresetn, out_valid_reg && out_data_reg.start_ok |-> out_data_reg.message_code == zws_pkg::MSG_OPENING && out_data_reg.phase == zws_pkg::PHC_PREOPEN, "accepted start did not open a zone")
    `ZWS_ASSERT(a_zone_in_cycle, aclk, aresetn, out_valid_reg && out_data_reg.active_zone != 4'd0 |-> out_data_reg.cycle_active, "zone open outside a cycle")

endmodule
